[rtl/core/mdt_pkg.sv]
package mdt_pkg;

	// Operation codes carried by an input item
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_EXPIRE = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_ZERO_DELAY = 2'd1;
	localparam logic [1:0] STAT_FULL       = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND  = 2'd3;

	// Timer actions
	localparam logic [1:0] ACT_LEAVE = 2'd0;
	localparam logic [1:0] ACT_STOP  = 2'd1;
	localparam logic [1:0] ACT_LOAD  = 2'd2;

	// Reset value of the period limit register
	localparam logic [31:0] MAX_PERIOD_RST = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  requester_id;
		logic [31:0] delay_us;
		logic [63:0] deadline;
		logic [63:0] now_us;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot_used;
		logic [63:0] target_time;
		logic [7:0]  expired_mask;
		logic [1:0]  timer_action;
		logic [31:0] load_period;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;        // capture item, do the insert write
		logic scan;        // issue a slot read at the scan address
		logic final_step;  // form the distance to the earliest deadline
		logic emit;        // finish re-arm, load the result register
	} cmd_t;

endpackage

[rtl/core/mdt_chan_if.sv]
interface mdt_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/mdt_ram.sv]
module mdt_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/mdt_ctrl.sv]
module mdt_ctrl #(
	parameter int SLOTS = 8,
	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mdt_pkg::cmd_t     cmd,
	output logic [ADDR_W-1:0] scan_addr
);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SLOTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_FINAL = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              out_valid_q;
	logic              in_acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign scan_addr = cnt_q;

	// Commands to the datapath
	always_comb begin
		cmd.load       = in_acc;
		cmd.scan       = (state_q == ST_SCAN);
		cmd.final_step = (state_q == ST_FINAL);
		cmd.emit       = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	// Sequencer: scan every slot once, then settle the timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_FINAL;
				ST_FINAL: state_q <= ST_DONE;
				ST_DONE: begin
					if (cmd.emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result valid flag of the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transaction completed");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_SCAN && cnt_q == '0))
		else $error("accepted item did not start a scan at slot zero");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.emit))
		else $error("result valid raised without an emit");
`endif
endmodule

[rtl/core/mdt_dp.sv]
module mdt_dp #(
	parameter int SLOTS = 8,
	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mdt_pkg::cmd_t        cmd,
	input  logic [ADDR_W-1:0]    scan_addr,
	input  mdt_pkg::item_t       item_data,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_data,
	output mdt_pkg::result_t     res_data
);
	localparam int SLOT_W = $clog2(SLOTS + 1);
	localparam int RAM_W  = 8 + 64;
	localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(SLOTS);

	// Configuration and table state
	logic [31:0]       cap_q;
	logic [SLOTS-1:0]  valid_q;
	logic [SLOT_W-1:0] armed_q;

	// Captured item
	logic [1:0]        op_q;
	logic [7:0]        id_q;
	logic [63:0]       match_q;
	logic [63:0]       now_q;

	// Per-item working registers
	logic [1:0]        status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [63:0]       target_q;
	logic [7:0]        mask_q;
	logic              found_q;
	logic [ADDR_W-1:0] best_q;
	logic [63:0]       best_dl_q;
	logic              best_vld_q;
	logic [63:0]       diff_q;
	mdt_pkg::result_t  res_q;

	// Read pipeline
	logic              chk_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [RAM_W-1:0]  rdata;

	// Combinational helpers
	logic [ADDR_W-1:0] free_idx;
	logic              have_free;
	logic              ins_go;
	logic [63:0]       ins_target;
	logic [7:0]        rd_req;
	logic [63:0]       rd_dl;
	logic              rd_v;
	logic [63:0]       age;
	logic [63:0]       lead;
	logic              exp_hit;
	logic              rm_hit;
	logic              keep;
	logic              ahead;
	logic [7:0]        hit_bit;
	logic [31:0]       cap_eff;
	logic [31:0]       period;

	// Lowest free slot
	always_comb begin
		free_idx  = '0;
		have_free = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx  = ADDR_W'(i);
				have_free = 1'b1;
			end
		end
	end

	assign ins_target = item_data.now_us + 64'(item_data.delay_us);
	assign ins_go     = cmd.load && (item_data.opcode == mdt_pkg::OP_INSERT)
		&& (item_data.delay_us != 32'd0) && have_free;

	mdt_ram #(
		.WIDTH(RAM_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ins_go),
		.waddr (free_idx),
		.wdata ({item_data.requester_id, ins_target}),
		.raddr (scan_addr),
		.rdata (rdata)
	);

	// Per-slot evaluation of the entry returned by the RAM
	assign rd_req  = rdata[RAM_W-1:64];
	assign rd_dl   = rdata[63:0];
	assign rd_v    = valid_q[idx_s1];
	assign age     = now_q - rd_dl;
	assign lead    = rd_dl - best_dl_q;
	assign exp_hit = (op_q == mdt_pkg::OP_EXPIRE) && rd_v && !age[63];
	assign rm_hit  = (op_q == mdt_pkg::OP_REMOVE) && rd_v && !found_q
		&& (rd_req == id_q) && (rd_dl == match_q);
	assign keep    = rd_v && !exp_hit && !rm_hit;
	assign ahead   = !best_vld_q || lead[63];
	assign hit_bit = 8'(1) << idx_s1;

	// Timer period, clamped to 1 .. limit
	always_comb begin
		cap_eff = (cap_q == 32'd0) ? 32'd1 : cap_q;
		if (diff_q == 64'd0 || diff_q[63]) begin
			period = 32'd1;
		end else if (diff_q > {32'd0, cap_eff}) begin
			period = cap_eff;
		end else begin
			period = diff_q[31:0];
		end
	end

	// Control state: limit register, valid bits, armed slot, read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= mdt_pkg::MAX_PERIOD_RST;
			valid_q <= '0;
			armed_q <= NO_SLOT;
			chk_s1  <= 1'b0;
			idx_s1  <= '0;
		end else begin
			chk_s1 <= cmd.scan;
			idx_s1 <= scan_addr;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (ins_go) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (cmd.load && item_data.opcode == mdt_pkg::OP_EXPIRE) begin
				armed_q <= NO_SLOT;
			end
			if (chk_s1 && (exp_hit || rm_hit)) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (chk_s1 && rm_hit && armed_q == SLOT_W'(idx_s1)) begin
				armed_q <= NO_SLOT;
			end
			if (cmd.emit) begin
				if (!best_vld_q) begin
					armed_q <= NO_SLOT;
				end else begin
					armed_q <= SLOT_W'(best_q);
				end
			end
		end
	end

	// Working registers for one item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			best_vld_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				found_q    <= 1'b0;
				best_vld_q <= 1'b0;
			end
			if (chk_s1 && rm_hit) begin
				found_q <= 1'b1;
			end
			if (chk_s1 && keep && ahead) begin
				best_vld_q <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= item_data.opcode;
			id_q    <= item_data.requester_id;
			match_q <= item_data.deadline;
			now_q   <= item_data.now_us;
			mask_q  <= '0;
			slot_q  <= ins_go ? SLOT_W'(free_idx) : NO_SLOT;
			target_q <= ins_go ? ins_target : 64'd0;
			if (item_data.opcode != mdt_pkg::OP_INSERT) begin
				status_q <= mdt_pkg::STAT_OK;
			end else if (item_data.delay_us == 32'd0) begin
				status_q <= mdt_pkg::STAT_ZERO_DELAY;
			end else if (!have_free) begin
				status_q <= mdt_pkg::STAT_FULL;
			end else begin
				status_q <= mdt_pkg::STAT_OK;
			end
		end
		if (chk_s1 && exp_hit) begin
			mask_q <= mask_q | hit_bit;
		end
		if (chk_s1 && rm_hit) begin
			slot_q <= SLOT_W'(idx_s1);
		end
		// Earliest deadline so far, ties stay with the lower slot
		if (chk_s1 && keep && ahead) begin
			best_q    <= idx_s1;
			best_dl_q <= rd_dl;
		end
		if (cmd.final_step) begin
			diff_q <= best_dl_q - now_q;
		end
		if (cmd.emit) begin
			res_q.status       <= (op_q == mdt_pkg::OP_REMOVE && !found_q)
				? mdt_pkg::STAT_NOT_FOUND : status_q;
			res_q.slot_used    <= 4'(slot_q);
			res_q.target_time  <= target_q;
			res_q.expired_mask <= mask_q;
			if (!best_vld_q) begin
				res_q.timer_action <= mdt_pkg::ACT_STOP;
				res_q.load_period  <= 32'd0;
			end else if (armed_q == SLOT_W'(best_q)) begin
				res_q.timer_action <= mdt_pkg::ACT_LEAVE;
				res_q.load_period  <= 32'd0;
			end else begin
				res_q.timer_action <= mdt_pkg::ACT_LOAD;
				res_q.load_period  <= period;
			end
		end
	end

	assign res_data = res_q;

`ifndef SYNTHESIS
	a_stop_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !best_vld_q) |=> (armed_q == NO_SLOT))
		else $error("timer stopped but a slot is still armed");

	a_armed_range: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q <= NO_SLOT)
		else $error("armed slot index out of range");

	a_mask_only_expire: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && op_q != mdt_pkg::OP_EXPIRE) |-> (mask_q == 8'd0))
		else $error("expired mask set outside an expiry event");
`endif
endmodule

[rtl/core/multi_slot_deadline_timer_unit.sv]
// Deadline table of SLOTS entries driving one one-shot timer. An item goes up to
// a registered result in steps: the accepting cycle does the capture and insert
// write, the scan state reads every slot through the slot RAM's single read port,
// and the drain, final and done states finish the earliest-deadline search, form
// the period and load the result register; the done state waits while the last
// result is not yet taken. One item is worked on at a time; a new item is taken
// as soon as the previous one has reached the result register.
module multi_slot_deadline_timer_unit #(
	parameter int SLOTS = 8
) (
	input logic        clk,
	input logic        arst_n,
	mdt_chan_if.sink   item,
	mdt_chan_if.source result,
	mdt_chan_if.sink   cfg
);
	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	mdt_pkg::cmd_t     cmd;
	logic [ADDR_W-1:0] scan_addr;
	logic              item_ready;
	logic              res_valid;
	mdt_pkg::result_t  res_data;

	// Configuration writes are always taken
	assign cfg.ready   = 1'b1;
	assign item.ready  = item_ready;
	assign result.valid = res_valid;
	assign result.data  = res_data;

	mdt_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item_ready),
		.out_valid (res_valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.scan_addr (scan_addr)
	);

	mdt_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.scan_addr (scan_addr),
		.item_data (item.data),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.res_data  (res_data)
	);
endmodule
